// ===== sv/rmq_pkg.sv =====
package rmq_pkg;

    localparam int MAT_W = 16;
    localparam int NUM_W = MAT_W + 1;
    localparam int SQ_SIDE_W = 2 + 3 * NUM_W;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } branch_t;

endpackage

// ===== sv/rmq_in_if.sv =====
interface rmq_in_if;
    import rmq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MAT_W-1:0] m00;
    logic signed [MAT_W-1:0] m01;
    logic signed [MAT_W-1:0] m02;
    logic signed [MAT_W-1:0] m10;
    logic signed [MAT_W-1:0] m11;
    logic signed [MAT_W-1:0] m12;
    logic signed [MAT_W-1:0] m20;
    logic signed [MAT_W-1:0] m21;
    logic signed [MAT_W-1:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// ===== sv/rmq_out_if.sv =====
interface rmq_out_if;
    import rmq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MAT_W-1:0] quat_w;
    logic signed [MAT_W-1:0] quat_x;
    logic signed [MAT_W-1:0] quat_y;
    logic signed [MAT_W-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== sv/rmq_sqrt_cell.sv =====
module rmq_sqrt_cell #(
    parameter int VW = 34,
    parameter int SQ = 17,
    parameter int K  = 0,
    parameter int SW = 53
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [VW-1:0] in_rem,
    input  logic [SQ-1:0] in_root,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [VW-1:0] out_rem,
    output logic [SQ-1:0] out_root,
    output logic [SW-1:0] out_side
);
    localparam int TW = 2 * SQ + 2;

    logic          valid_reg;
    logic [VW-1:0] rem_reg, rem_next;
    logic [SQ-1:0] root_reg, root_next;
    logic [SW-1:0] side_reg;
    logic [TW-1:0] inc, remx;
    logic          take;

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    always_comb
    begin
        inc       = (TW'(in_root) << (K + 1)) + (TW'(1) << (2 * K));
        remx      = TW'(in_rem);
        take      = remx >= inc;
        rem_next  = take ? VW'(remx - inc) : in_rem;
        root_next = in_root | (SQ'(take) << K);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;
endmodule

// ===== sv/rmq_div_cell.sv =====
module rmq_div_cell #(
    parameter int NW  = 35,
    parameter int SW  = 18,
    parameter int QB  = 15,
    parameter int K   = 0,
    parameter int DSW = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0][NW-1:0]   in_rem,
    input  logic [2:0][QB-1:0]   in_quo,
    input  logic [SW-1:0]        in_div,
    input  logic [DSW-1:0]       in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0][NW-1:0]   out_rem,
    output logic [2:0][QB-1:0]   out_quo,
    output logic [SW-1:0]        out_div,
    output logic [DSW-1:0]       out_side
);
    logic               valid_reg;
    logic [2:0][NW-1:0] rem_reg, rem_next;
    logic [2:0][QB-1:0] quo_reg, quo_next;
    logic [SW-1:0]      div_reg;
    logic [DSW-1:0]     side_reg;
    logic [NW-1:0]      dvs;

    // one quotient bit for each of the three lanes
    always_comb
    begin
        dvs = NW'(in_div) << K;
        for (int l = 0; l < 3; l++)
        begin
            if (in_rem[l] >= dvs)
            begin
                rem_next[l] = in_rem[l] - dvs;
                quo_next[l] = in_quo[l] | (QB'(1) << K);
            end
            else
            begin
                rem_next[l] = in_rem[l];
                quo_next[l] = in_quo[l];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;
endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion by Shepperd's four-branch method, all values
// signed fixed point with FRAC_BITS fraction bits. One matrix is taken every cycle
// while quat.ready does not stall the pipeline, and results come out in order.
// The stages are one register for branch select, one square root cell per root bit,
// where SQ = (max(FRAC_BITS,17) + 3 + FRAC_BITS + 1) / 2 is the root width, one
// register to form the dividends, one divider cell per quotient bit (three lanes
// each), and the output register. Every component saturates to plus or minus one.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic  clk,
    input  logic  rst_n,
    rmq_in_if.sink    mat,
    rmq_out_if.source quat
);
    localparam int DW  = (FRAC_BITS > 17 ? FRAC_BITS : 17) + 3;
    localparam int VW  = DW + FRAC_BITS;
    localparam int SQ  = (VW + 1) / 2;
    localparam int NW  = SQ + FRAC_BITS + 4;
    localparam int QB  = FRAC_BITS + 1;
    localparam int DSW = 2 + SQ + 9;
    localparam logic signed [DW-1:0] D_ONE = DW'(1) << FRAC_BITS;
    localparam logic [QB-1:0] Q_ONE = QB'(1) << FRAC_BITS;
    localparam logic [SQ-1:0] R_ONE = SQ'(1) << FRAC_BITS;
    localparam logic [SQ-1:0] R_MAX = SQ'(32767);

    // ---------------- front: branch select and radicand ----------------
    logic signed [DW-1:0]    a0, a4, a8, trace, d;
    logic signed [NUM_W-1:0] n0, n1, n2;
    branch_t                 br;
    logic                    fr_valid_reg, fr_ready;
    logic [VW-1:0]           fr_rem_reg;
    logic [SQ_SIDE_W-1:0]    fr_side_reg;

    always_comb
    begin
        a0    = DW'(mat.m00);
        a4    = DW'(mat.m11);
        a8    = DW'(mat.m22);
        trace = a0 + a4 + a8;
        if (trace > 0)
        begin
            br = BR_W;
            d  = D_ONE + trace;
            n0 = NUM_W'(mat.m21) - NUM_W'(mat.m12);
            n1 = NUM_W'(mat.m02) - NUM_W'(mat.m20);
            n2 = NUM_W'(mat.m10) - NUM_W'(mat.m01);
        end
        else if (mat.m00 > mat.m11 && mat.m00 > mat.m22)
        begin
            br = BR_X;
            d  = D_ONE + a0 - a4 - a8;
            n0 = NUM_W'(mat.m21) - NUM_W'(mat.m12);
            n1 = NUM_W'(mat.m01) + NUM_W'(mat.m10);
            n2 = NUM_W'(mat.m02) + NUM_W'(mat.m20);
        end
        else if (mat.m11 > mat.m22)
        begin
            br = BR_Y;
            d  = D_ONE + a4 - a0 - a8;
            n0 = NUM_W'(mat.m02) - NUM_W'(mat.m20);
            n1 = NUM_W'(mat.m01) + NUM_W'(mat.m10);
            n2 = NUM_W'(mat.m21) + NUM_W'(mat.m12);
        end
        else
        begin
            br = BR_Z;
            d  = D_ONE + a8 - a0 - a4;
            n0 = NUM_W'(mat.m10) - NUM_W'(mat.m01);
            n1 = NUM_W'(mat.m02) + NUM_W'(mat.m20);
            n2 = NUM_W'(mat.m21) + NUM_W'(mat.m12);
        end
    end

    logic [SQ:0]                     sq_v, sq_r;
    logic [SQ:0][VW-1:0]             sq_rem;
    logic [SQ:0][SQ-1:0]             sq_root;
    logic [SQ:0][SQ_SIDE_W-1:0]      sq_side;

    assign fr_ready  = !fr_valid_reg || sq_r[0];
    assign mat.ready = fr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (fr_ready)
        begin
            fr_valid_reg <= mat.valid;
        end
    end

    // non-positive radicand gives a zero root
    always_ff @(posedge clk)
    begin
        if (fr_ready && mat.valid)
        begin
            fr_rem_reg  <= (d > 0) ? (VW'(unsigned'(d)) << FRAC_BITS) : '0;
            fr_side_reg <= {br, n0, n1, n2};
        end
    end

    // ---------------- square root chain ----------------
    assign sq_v[0]    = fr_valid_reg;
    assign sq_rem[0]  = fr_rem_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = fr_side_reg;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        rmq_sqrt_cell #(
            .VW(VW), .SQ(SQ), .K(SQ - 1 - i), .SW(SQ_SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (sq_v[i]),
            .in_ready (sq_r[i]),
            .in_rem   (sq_rem[i]),
            .in_root  (sq_root[i]),
            .in_side  (sq_side[i]),
            .out_valid(sq_v[i+1]),
            .out_ready(sq_r[i+1]),
            .out_rem  (sq_rem[i+1]),
            .out_root (sq_root[i+1]),
            .out_side (sq_side[i+1])
        );
    end

    // ---------------- dividend preparation ----------------
    logic [QB:0]                     dv_v, dv_r;
    logic [QB:0][2:0][NW-1:0]        dv_rem;
    logic [QB:0][2:0][QB-1:0]        dv_quo;
    logic [QB:0][SQ:0]               dv_div;
    logic [QB:0][DSW-1:0]            dv_side;

    logic                   pr_valid_reg;
    logic [2:0][NW-1:0]     pr_rem_reg, pr_rem_next;
    logic [SQ:0]            pr_div_reg, pr_div_next;
    logic [DSW-1:0]         pr_side_reg, pr_side_next;
    logic [SQ-1:0]          r_in, big;
    logic [2:0]             sgn, zro, ovf;
    logic signed [NUM_W-1:0] num [3];
    logic [NUM_W-1:0]       mag;
    logic [NW-1:0]          lim;

    always_comb
    begin
        r_in        = sq_root[SQ];
        pr_div_next = {r_in, 1'b0};
        big         = SQ'(({1'b0, r_in} + (SQ + 1)'(1)) >> 1);
        lim         = NW'(pr_div_next) << (FRAC_BITS + 1);
        num[0]      = sq_side[SQ][3*NUM_W-1:2*NUM_W];
        num[1]      = sq_side[SQ][2*NUM_W-1:NUM_W];
        num[2]      = sq_side[SQ][NUM_W-1:0];
        mag         = '0;
        for (int l = 0; l < 3; l++)
        begin
            mag = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
            // rounding adds s/2, which is r
            pr_rem_next[2-l] = (NW'(mag) << FRAC_BITS) + NW'(r_in);
            sgn[2-l] = num[l][NUM_W-1];
            zro[2-l] = (num[l] == '0);
            ovf[2-l] = pr_rem_next[2-l] >= lim;
        end
        pr_side_next = {sq_side[SQ][SQ_SIDE_W-1:SQ_SIDE_W-2], big, sgn, zro, ovf};
    end

    assign sq_r[SQ] = !pr_valid_reg || dv_r[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (sq_r[SQ])
        begin
            pr_valid_reg <= sq_v[SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_r[SQ] && sq_v[SQ])
        begin
            pr_rem_reg  <= pr_rem_next;
            pr_div_reg  <= pr_div_next;
            pr_side_reg <= pr_side_next;
        end
    end

    // ---------------- divider chain ----------------
    assign dv_v[0]    = pr_valid_reg;
    assign dv_rem[0]  = pr_rem_reg;
    assign dv_quo[0]  = '0;
    assign dv_div[0]  = pr_div_reg;
    assign dv_side[0] = pr_side_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        rmq_div_cell #(
            .NW(NW), .SW(SQ + 1), .QB(QB), .K(QB - 1 - i), .DSW(DSW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (dv_v[i]),
            .in_ready (dv_r[i]),
            .in_rem   (dv_rem[i]),
            .in_quo   (dv_quo[i]),
            .in_div   (dv_div[i]),
            .in_side  (dv_side[i]),
            .out_valid(dv_v[i+1]),
            .out_ready(dv_r[i+1]),
            .out_rem  (dv_rem[i+1]),
            .out_quo  (dv_quo[i+1]),
            .out_div  (dv_div[i+1]),
            .out_side (dv_side[i+1])
        );
    end

    // ---------------- saturation and output register ----------------
    logic                     q_valid_reg;
    logic [3:0][MAT_W-1:0]    q_reg, q_next;
    logic [2:0][MAT_W-1:0]    lane;
    logic [MAT_W-1:0]         bigv;
    logic [QB-1:0]            qm;
    logic [SQ-1:0]            bm;
    branch_t                  obr;
    logic [2:0]               osg, ozr, oov;

    always_comb
    begin
        obr = branch_t'(dv_side[QB][DSW-1:DSW-2]);
        bm  = dv_side[QB][SQ+8:9];
        osg = dv_side[QB][8:6];
        ozr = dv_side[QB][5:3];
        oov = dv_side[QB][2:0];
        qm  = '0;
        for (int l = 0; l < 3; l++)
        begin
            qm = (oov[l] || dv_quo[QB][l] > Q_ONE) ? Q_ONE : dv_quo[QB][l];
            if (ozr[l])
            begin
                lane[l] = '0;
            end
            else if (osg[l])
            begin
                lane[l] = (32'(qm) > 32'd32768) ? MAT_W'(16'sh8000) : -MAT_W'(qm);
            end
            else
            begin
                lane[l] = (32'(qm) > 32'd32767) ? MAT_W'(32767) : MAT_W'(qm);
            end
        end
        if (bm > R_ONE)
        begin
            bm = R_ONE;
        end
        bigv = (bm > R_MAX) ? MAT_W'(32767) : MAT_W'(bm);
        case (obr)
            BR_W:    q_next = {lane[0], lane[1], lane[2], bigv};
            BR_X:    q_next = {lane[0], lane[1], bigv, lane[2]};
            BR_Y:    q_next = {lane[0], bigv, lane[1], lane[2]};
            BR_Z:    q_next = {bigv, lane[0], lane[1], lane[2]};
            default: q_next = '0;
        endcase
    end

    assign dv_r[QB] = !q_valid_reg || quat.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (dv_r[QB])
        begin
            q_valid_reg <= dv_v[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_r[QB] && dv_v[QB])
        begin
            q_reg <= q_next;
        end
    end

    // q_reg packs z, y, x, w from high to low
    assign quat.valid  = q_valid_reg;
    assign quat.quat_w = q_reg[0];
    assign quat.quat_x = q_reg[1];
    assign quat.quat_y = q_reg[2];
    assign quat.quat_z = q_reg[3];
endmodule

// ===== tb/rmq_checker.sv =====
`timescale 1ns / 1ps

module rmq_checker
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    rmq_in_if.sink    mat,
    rmq_out_if.sink   quat,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic signed [MAT_W-1:0] w;
        logic signed [MAT_W-1:0] x;
        logic signed [MAT_W-1:0] y;
        logic signed [MAT_W-1:0] z;
    } quat_t;

    quat_t expected_quats[$];
    int    errors;

    assign fail_count = errors;
    assign pending    = expected_quats.size();

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (v > one) v = one;
        if (v < -one) v = -one;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // numerator over s at scale one, rounded half away from zero
    function automatic longint scaled_div(longint num, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (num == 0) return 0;
        if (s == 0) return clamp_unit(num > 0 ? one : -one);
        mag = num < 0 ? -num : num;
        q = ((mag << FRAC_BITS) + (s >> 1)) / s;
        if (q > one) q = one;
        return clamp_unit(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic quat_t predict_quat(longint a00, longint a01, longint a02,
                                           longint a10, longint a11, longint a12,
                                           longint a20, longint a21, longint a22);
        longint one;
        longint trace;
        longint d;
        longint unsigned root;
        longint unsigned s;
        longint q[4];
        branch_t br;
        quat_t res;
        one   = longint'(1) << FRAC_BITS;
        trace = a00 + a11 + a22;
        root  = 0;
        if (trace > 0)
        begin
            br = BR_W;
            d  = one + trace;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            br = BR_X;
            d  = one + a00 - a11 - a22;
        end
        else if (a11 > a22)
        begin
            br = BR_Y;
            d  = one + a11 - a00 - a22;
        end
        else
        begin
            br = BR_Z;
            d  = one + a22 - a00 - a11;
        end
        if (d > 0) root = int_sqrt(longint'(d) << FRAC_BITS);
        s = root << 1;
        case (br)
            BR_W:
            begin
                q[1] = scaled_div(a21 - a12, s);
                q[2] = scaled_div(a02 - a20, s);
                q[3] = scaled_div(a10 - a01, s);
            end
            BR_X:
            begin
                q[0] = scaled_div(a21 - a12, s);
                q[2] = scaled_div(a01 + a10, s);
                q[3] = scaled_div(a02 + a20, s);
            end
            BR_Y:
            begin
                q[0] = scaled_div(a02 - a20, s);
                q[1] = scaled_div(a01 + a10, s);
                q[3] = scaled_div(a21 + a12, s);
            end
            default:
            begin
                q[0] = scaled_div(a10 - a01, s);
                q[1] = scaled_div(a02 + a20, s);
                q[2] = scaled_div(a21 + a12, s);
            end
        endcase
        q[int'(br)] = clamp_unit(longint'((root + 1) >> 1));
        res.w = q[0][MAT_W-1:0];
        res.x = q[1][MAT_W-1:0];
        res.y = q[2][MAT_W-1:0];
        res.z = q[3][MAT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quat_t got;
        quat_t exp_q;
        if (!rst_n)
        begin
            errors = 0;
            expected_quats.delete();
        end
        else
        begin
            if (quat.valid && quat.ready)
            begin
                got = '{quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z};
                if (expected_quats.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: w=%0d x=%0d y=%0d z=%0d",
                                 got.w, got.x, got.y, got.z);
                end
                else
                begin
                    exp_q = expected_quats.pop_front();
                    if (got !== exp_q)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                                     exp_q.w, exp_q.x, exp_q.y, exp_q.z,
                                     got.w, got.x, got.y, got.z);
                    end
                end
            end
            if (mat.valid && mat.ready)
                expected_quats.insert(expected_quats.size(),
                                      predict_quat(mat.m00, mat.m01, mat.m02,
                                                   mat.m10, mat.m11, mat.m12,
                                                   mat.m20, mat.m21, mat.m22));
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rmq_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int NUM_RANDOM = 1250;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    longint cycles;
    logic no_idle;

    rmq_in_if  mat();
    rmq_out_if quat();

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n), .mat(mat), .quat(quat)
    );

    rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .clk(clk), .rst_n(rst_n), .mat(mat), .quat(quat),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    typedef logic signed [MAT_W-1:0] entry_t;

    function automatic entry_t rand_entry();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return entry_t'($urandom);
        if (sel == 1)
        begin
            case ($urandom_range(0, 4))
                0: return entry_t'(ONE);
                1: return entry_t'(-ONE);
                2: return 16'sh7fff;
                3: return 16'sh8000;
                default: return 0;
            endcase
        end
        return entry_t'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endfunction

    // a genuine rotation from a random unit quaternion
    task automatic make_rotation(output entry_t m[9]);
        real qw, qx, qy, qz, n;
        real r[9];
        qw = $urandom_range(0, 2000) / 1000.0 - 1.0;
        qx = $urandom_range(0, 2000) / 1000.0 - 1.0;
        qy = $urandom_range(0, 2000) / 1000.0 - 1.0;
        qz = $urandom_range(0, 2000) / 1000.0 - 1.0;
        n = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        if (n < 0.01)
        begin
            qw = 1.0;
            n  = 1.0;
        end
        qw /= n; qx /= n; qy /= n; qz /= n;
        r[0] = 1 - 2 * (qy * qy + qz * qz);
        r[1] = 2 * (qx * qy - qz * qw);
        r[2] = 2 * (qx * qz + qy * qw);
        r[3] = 2 * (qx * qy + qz * qw);
        r[4] = 1 - 2 * (qx * qx + qz * qz);
        r[5] = 2 * (qy * qz - qx * qw);
        r[6] = 2 * (qx * qz - qy * qw);
        r[7] = 2 * (qy * qz + qx * qw);
        r[8] = 1 - 2 * (qx * qx + qy * qy);
        foreach (r[i]) m[i] = entry_t'($rtoi(r[i] * ONE + (r[i] >= 0 ? 0.5 : -0.5)));
    endtask

    task automatic send_matrix(input entry_t m[9]);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            mat.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mat.valid <= 1'b1;
        mat.m00 <= m[0]; mat.m01 <= m[1]; mat.m02 <= m[2];
        mat.m10 <= m[3]; mat.m11 <= m[4]; mat.m12 <= m[5];
        mat.m20 <= m[6]; mat.m21 <= m[7]; mat.m22 <= m[8];
        @(posedge clk);
        while (!mat.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver side stalls, with one long hold-off early on
    initial
    begin
        int gap;
        quat.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        repeat (30) @(negedge clk);
        quat.ready <= 1'b0;
        repeat (200) @(negedge clk);
        forever
        begin
            quat.ready <= 1'b1;
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 6) == 0)
            begin
                gap = $urandom_range(1, 13);
                quat.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        entry_t m[9];
        int     drain;
        cycles       = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        mat.valid    = 1'b0;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11} = '0;
        {mat.m12, mat.m20, mat.m21, mat.m22} = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity and the three half-turns pick each branch
        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};              send_matrix(m);
        m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};            send_matrix(m);
        m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};            send_matrix(m);
        m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};            send_matrix(m);
        // ties on the diagonal with zero trace
        m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};              send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(m);
        // not a rotation: negative diagonals that fall to the z branch
        m = '{-ONE, 5, -7, 3, -ONE, 9, -2, 4, -ONE};         send_matrix(m);
        m = '{16'sh8000, 100, -100, 0, 16'sh8000, 0, 1, -1, 16'sh8000}; send_matrix(m);
        // saturation of off-diagonal quotients
        m = '{ONE, 16'sh7fff, 16'sh8000, 16'sh8000, ONE, 16'sh7fff,
              16'sh7fff, 16'sh8000, ONE};                    send_matrix(m);
        m = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};   send_matrix(m);
        m = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};   send_matrix(m);
        m = '{16'sh7fff, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(m);
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};           send_matrix(m);
        m = '{1, 1, 1, 1, 1, 1, 1, 1, 1};                    send_matrix(m);
        for (int k = 0; k < 8; k++)
        begin
            make_rotation(m);
            send_matrix(m);
        end

        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            if (k > NUM_RANDOM - 150) no_idle = 1'b1;
            if ($urandom_range(0, 3) != 0)
                make_rotation(m);
            else
                foreach (m[i]) m[i] = rand_entry();
            send_matrix(m);
        end
        mat.valid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (60) @(posedge clk);
        if (pending == 0 && fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
